>>> src/dsga_pkg.sv
// ----------------------------------------------------------------------------
// dsga_pkg
// Shared widths, register indexes, reset values and types of the disc splat
// grid accumulator.
// ----------------------------------------------------------------------------
package dsga_pkg;

	// grid size defaults
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	// field widths
	localparam int GRID_W  = 9;
	localparam int COORD_W = 8;
	localparam int RAD_W   = 12;
	localparam int WGT_W   = 20;
	localparam int FLOOR_W = 16;
	localparam int CELL_W  = 32;
	localparam int SUM_W   = 48;
	localparam int LIM_W   = 17;
	localparam int SQ_W    = 17;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_VALUE = 2'd2;

	// request codes
	localparam logic REQ_STAMP = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// reset values
	localparam logic [GRID_W-1:0]  RESET_GRID  = 9'd256;
	localparam logic [FLOOR_W-1:0] RESET_FLOOR = 16'd256;

	// default derived widths for the scan unit (256 x 256 grid)
	localparam int ADDR_W_DEF = 16;
	localparam int IDX_W_DEF  = 18;

	// status of the scan unit as seen by the cell update logic
	typedef struct packed {
		logic probe_valid;
		logic busy;
	} scan_status_t;

endpackage

>>> src/dsga_scan.sv
// ----------------------------------------------------------------------------
// dsga_scan
// Walks the bounding box of a disc column by column and issues the address of
// every in-grid cell that lies inside the disc, one cell per cycle.
// ----------------------------------------------------------------------------
module dsga_scan
	import dsga_pkg::*;
#(
	parameter int AW = ADDR_W_DEF,
	parameter int IW = IDX_W_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [COORD_W-1:0]  center_x,
	input  logic [COORD_W-1:0]  center_y,
	input  logic [RAD_W-1:0]    radius,
	input  logic [GRID_W-1:0]   width,
	input  logic [GRID_W-1:0]   height,
	output scan_status_t        status,
	output logic [AW-1:0]       probe_addr
);

	typedef enum logic [2:0] {
		SC_IDLE  = 3'b001,
		SC_SETUP = 3'b010,
		SC_RUN   = 3'b100
	} scan_state_t;

	scan_state_t          state_q;
	logic [COORD_W-1:0]   cx_q;
	logic [COORD_W-1:0]   cy_q;
	logic [RAD_W-1:0]     r_q;
	logic [LIM_W-1:0]     lim_q;
	logic [GRID_W-1:0]    x_q;
	logic [GRID_W-1:0]    y_q;
	logic [GRID_W-1:0]    y0_q;
	logic [IW-1:0]        col_q;
	logic [IW-1:0]        addr_q;

	logic                 v_s1;
	logic [AW-1:0]        addr_s1;
	logic [SQ_W-1:0]      dxsq_s1;
	logic [SQ_W-1:0]      dysq_s1;
	logic                 probe_v_q;
	logic [AW-1:0]        probe_addr_q;

	logic [RAD_W-1:0]     cx16;
	logic [RAD_W-1:0]     cy16;
	logic [RAD_W-1:0]     cx_lo;
	logic [RAD_W-1:0]     cy_lo;
	logic [GRID_W-1:0]    x0;
	logic [GRID_W-1:0]    y0;
	logic                 x_ok;
	logic                 y_ok;
	logic                 emit;
	logic signed [9:0]    dx;
	logic signed [9:0]    dy;
	logic signed [19:0]   dx_prod;
	logic signed [19:0]   dy_prod;
	logic [24:0]          rsq_rnd;
	logic [IW-1:0]        col_first;
	logic [SQ_W:0]        dist_sq;
	logic                 in_disc;

	// first column and row of the box: trunc(center - radius), never below 0
	always_comb begin
		cx16  = {center_x, 4'b0000};
		cy16  = {center_y, 4'b0000};
		cx_lo = cx16 - radius;
		cy_lo = cy16 - radius;
		x0    = (cx16 >= radius) ? {1'b0, cx_lo[RAD_W-1:4]} : '0;
		y0    = (cy16 >= radius) ? {1'b0, cy_lo[RAD_W-1:4]} : '0;
	end

	always_comb begin
		x_ok = (x_q < width) &&
			({x_q, 4'b0000} < ({1'b0, cx_q, 4'b0000} + {1'b0, r_q}));
		y_ok = (y_q < height) &&
			({y_q, 4'b0000} < ({1'b0, cy_q, 4'b0000} + {1'b0, r_q}));
		emit = (state_q == SC_RUN) && x_ok && y_ok;
	end

	always_comb begin
		rsq_rnd   = 25'(r_q) * 25'(r_q) + 25'd128;
		col_first = IW'(y0_q) * IW'(width) + IW'(x_q);
		dx        = $signed({2'b00, cx_q}) - $signed({1'b0, x_q});
		dy        = $signed({2'b00, cy_q}) - $signed({1'b0, y_q});
		dx_prod   = 20'(dx) * 20'(dx);
		dy_prod   = 20'(dy) * 20'(dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			case (state_q)
				SC_IDLE: begin
					if (start) state_q <= SC_SETUP;
				end
				SC_SETUP: begin
					state_q <= SC_RUN;
				end
				SC_RUN: begin
					if (!x_ok) state_q <= SC_IDLE;
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				if (start) begin
					cx_q <= center_x;
					cy_q <= center_y;
					r_q  <= radius;
					x_q  <= x0;
					y0_q <= y0;
				end
			end
			SC_SETUP: begin
				// inside test: 256*d^2 - 128 <= R^2  <=>  d^2 <= (R^2 + 128) >> 8
				lim_q  <= rsq_rnd[24:8];
				col_q  <= col_first;
				addr_q <= col_first;
				y_q    <= y0_q;
			end
			SC_RUN: begin
				if (x_ok) begin
					if (y_ok) begin
						y_q    <= y_q + 1'b1;
						addr_q <= addr_q + IW'(width);
					end else begin
						// advance to the top of the next column
						x_q    <= x_q + 1'b1;
						y_q    <= y0_q;
						col_q  <= col_q + 1'b1;
						addr_q <= col_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		dist_sq = {1'b0, dxsq_s1} + {1'b0, dysq_s1};
		in_disc = dist_sq <= {1'b0, lim_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			probe_v_q <= 1'b0;
		end else begin
			v_s1      <= emit;
			probe_v_q <= v_s1 && in_disc;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1      <= addr_q[AW-1:0];
		dxsq_s1      <= dx_prod[SQ_W-1:0];
		dysq_s1      <= dy_prod[SQ_W-1:0];
		probe_addr_q <= addr_s1;
	end

	assign status.probe_valid = probe_v_q;
	assign status.busy        = (state_q != SC_IDLE) || v_s1 || probe_v_q;
	assign probe_addr         = probe_addr_q;

endmodule

>>> src/disc_splat_grid_accumulator.sv
// ----------------------------------------------------------------------------
// disc_splat_grid_accumulator
// Grid of signed Q8 cells with disc stamps, single cell queries and a
// saturating running sum of all applied weights.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready, one result leaves per request on
// out_valid/out_ready, registers are written on cfg_valid/cfg_ready
// (always ready; write only while no request is in flight).
// A stamp walks the disc's bounding box column by column through the scan
// unit; each covered cell is read, updated and written back in the single
// cell memory, one cell per cycle. At the end of each column the scan moves
// to the top of the next one without issuing a cell. A query reads its cell
// in ST_QREAD and ST_QDATA; one outside the grid goes straight to ST_DONE.
// One request is worked on at a time; the next one is accepted once the
// previous result sits in the output register.
// After reset the block writes the reset floor value into every cell, one
// cell per cycle, over the MAX_WIDTH * MAX_HEIGHT cells (65536 by default) and
// holds in_ready low meanwhile. A stalled receiver holds the result in the
// output register; the next request may still finish its work, then waits.
// ----------------------------------------------------------------------------
module disc_splat_grid_accumulator
	import dsga_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    req_type,
	input  logic [COORD_W-1:0]      center_x,
	input  logic [COORD_W-1:0]      center_y,
	input  logic [RAD_W-1:0]        radius,
	input  logic signed [WGT_W-1:0] weight,

	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [CELL_W-1:0] cell_value,
	output logic signed [SUM_W-1:0] threat_sum,
	output logic                    out_of_grid,

	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int IW = (AW > 2 * GRID_W) ? AW : 2 * GRID_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);
	localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
	localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_QREAD = 6'b001000,
		ST_QDATA = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_addr_q;
	logic [GRID_W-1:0]    grid_width_q;
	logic [GRID_W-1:0]    grid_height_q;
	logic [FLOOR_W-1:0]   floor_q;
	logic [WGT_W-1:0]     weight_q;
	logic [AW-1:0]        qaddr_q;
	logic [CELL_W-1:0]    res_cell_q;
	logic                 res_oog_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 out_valid_q;
	logic                 v_s2;
	logic [AW-1:0]        addr_s2;

	logic [CELL_W-1:0]    mem [CELL_COUNT];
	logic [CELL_W-1:0]    rdata_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [CELL_W-1:0]    mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;

	logic [GRID_W-1:0]    w_eff;
	logic [GRID_W-1:0]    h_eff;
	logic                 in_acc;
	logic                 stamp_start;
	logic                 q_oog;
	logic [IW-1:0]        q_idx;
	logic                 out_load;
	scan_status_t         scan_st;
	logic [AW-1:0]        probe_addr;

	logic [CELL_W:0]      cell_add;
	logic [CELL_W-1:0]    cell_sat;
	logic [CELL_W-1:0]    floor_ext;
	logic [CELL_W-1:0]    cell_new;
	logic [SUM_W:0]       sum_add;
	logic [SUM_W-1:0]     sum_sat;

	// effective grid size saturates at the storage size
	always_comb begin
		w_eff = ({4'b0000, grid_width_q} > MAXW) ? MAXW[GRID_W-1:0] : grid_width_q;
		h_eff = ({4'b0000, grid_height_q} > MAXH) ? MAXH[GRID_W-1:0] : grid_height_q;
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign stamp_start = in_acc && (req_type == REQ_STAMP);
	assign cfg_ready   = 1'b1;
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		q_oog = ({1'b0, center_x} >= w_eff) || ({1'b0, center_y} >= h_eff);
		q_idx = IW'(center_y) * IW'(w_eff) + IW'(center_x);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= RESET_GRID;
			grid_height_q <= RESET_GRID;
			floor_q       <= RESET_FLOOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[GRID_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[GRID_W-1:0];
				REG_FLOOR_VALUE: floor_q       <= cfg_data[FLOOR_W-1:0];
				default: ;
			endcase
		end
	end

	dsga_scan #(
		.AW (AW),
		.IW (IW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (stamp_start),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.width      (w_eff),
		.height     (h_eff),
		.status     (scan_st),
		.probe_addr (probe_addr)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (req_type == REQ_STAMP) state_q <= ST_SCAN;
						else if (q_oog)            state_q <= ST_DONE;
						else                       state_q <= ST_QREAD;
					end
				end
				ST_SCAN: begin
					// wait until the last write-back has left the pipeline
					if (!scan_st.busy && !v_s2) state_q <= ST_DONE;
				end
				ST_QREAD: state_q <= ST_QDATA;
				ST_QDATA: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request payload and per-request result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			weight_q   <= weight;
			qaddr_q    <= q_idx[AW-1:0];
			res_cell_q <= '0;
			res_oog_q  <= (req_type == REQ_QUERY) && q_oog;
		end else if (state_q == ST_QDATA) begin
			res_cell_q <= rdata_q - floor_ext;
		end
	end

	// read-modify-write stage: data for the probe issued last cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= scan_st.probe_valid;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= probe_addr;
	end

	always_comb begin
		floor_ext = {{(CELL_W-FLOOR_W){1'b0}}, floor_q};
		cell_add  = {rdata_q[CELL_W-1], rdata_q} +
			{{(CELL_W+1-WGT_W){weight_q[WGT_W-1]}}, weight_q};
		if (cell_add[CELL_W] != cell_add[CELL_W-1])
			cell_sat = {cell_add[CELL_W], {(CELL_W-1){~cell_add[CELL_W]}}};
		else
			cell_sat = cell_add[CELL_W-1:0];
		cell_new = ($signed(cell_sat) < $signed(floor_ext)) ? floor_ext : cell_sat;

		sum_add = {sum_q[SUM_W-1], sum_q} +
			{{(SUM_W+1-WGT_W){weight_q[WGT_W-1]}}, weight_q};
		if (sum_add[SUM_W] != sum_add[SUM_W-1])
			sum_sat = {sum_add[SUM_W], {(SUM_W-1){~sum_add[SUM_W]}}};
		else
			sum_sat = sum_add[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (v_s2) begin
			sum_q <= sum_sat;
		end
	end

	// cell memory: one write port, one registered read port
	always_comb begin
		mem_we    = (state_q == ST_CLEAR) || v_s2;
		mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : addr_s2;
		mem_wdata = (state_q == ST_CLEAR) ?
			{{(CELL_W-FLOOR_W){1'b0}}, RESET_FLOOR} : cell_new;
		mem_re    = scan_st.probe_valid || (state_q == ST_QREAD);
		mem_raddr = scan_st.probe_valid ? probe_addr : qaddr_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cell_value  <= res_cell_q;
			threat_sum  <= sum_q;
			out_of_grid <= res_oog_q;
		end
	end

	assign out_valid = out_valid_q;

	// cell probes come only from a running stamp
	a_probe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_st.probe_valid |-> state_q == ST_SCAN)
		else $error("cell probe outside a stamp");

	// write-back never leaves a cell below the floor
	a_wb_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && state_q != ST_CLEAR) |-> $signed(mem_wdata) >= $signed(floor_ext))
		else $error("write-back below floor value");

	// running sum moves only while a stamp is being applied
	a_sum_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_SCAN |=> $stable(sum_q))
		else $error("running sum changed outside a stamp");

	// no request is taken while the clearing pass runs or a result is pending
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR || state_q == ST_DONE) |-> !in_ready)
		else $error("request accepted while busy");

endmodule

>>> verif/tb_disc_splat_grid_accumulator.sv
// ----------------------------------------------------------------------------
// tb_disc_splat_grid_accumulator
// Self-checking bench for the disc splat grid accumulator. A clocked driver
// feeds stamp and query requests from a queue, and a clocked monitor checks
// each result against an in-bench grid model with its own cell array and
// running sum. Directed requests cover the edges of the grid and the fields,
// a run of repeated stamps piles one cell up with the largest weight, and
// random phases sweep grid sizes and floor values under bursty input and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_disc_splat_grid_accumulator;
	timeunit 1ns;
	timeprecision 1ps;

	import dsga_pkg::*;

	localparam int CELLS       = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
	localparam int LONG_HOLD   = 3000;
	localparam int SOAK_STAMPS = 64;
	localparam int PHASE_ITEMS = 400;
	localparam int MAX_SHOWN   = 10;

	localparam logic [CFG_IDX_W-1:0]    REG_SPARE = 2'd3;
	localparam logic signed [WGT_W-1:0] WGT_MAX   = {1'b0, {(WGT_W-1){1'b1}}};
	localparam logic signed [WGT_W-1:0] WGT_MIN   = {1'b1, {(WGT_W-1){1'b0}}};
	localparam logic [RAD_W-1:0]        RAD_MAX   = '1;

	localparam longint CELL_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam longint CELL_LO = -CELL_HI - 1;
	localparam longint SUM_HI  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_LO  = -SUM_HI - 1;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_mode_t;

	typedef struct {
		logic                    kind;
		logic [COORD_W-1:0]      cx;
		logic [COORD_W-1:0]      cy;
		logic [RAD_W-1:0]        rad;
		logic signed [WGT_W-1:0] wgt;
		bit                      drain;
	} splat_req_t;

	typedef struct {
		logic signed [CELL_W-1:0] cval;
		logic signed [SUM_W-1:0]  sum;
		logic                     oog;
	} grid_resp_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     req_type = REQ_STAMP;
	logic [COORD_W-1:0]       center_x = '0;
	logic [COORD_W-1:0]       center_y = '0;
	logic [RAD_W-1:0]         radius = '0;
	logic signed [WGT_W-1:0]  weight = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [CELL_W-1:0] cell_value;
	logic signed [SUM_W-1:0]  threat_sum;
	logic                     out_of_grid;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	// grid model
	bit signed [CELL_W-1:0] cell_mem [CELLS];
	bit signed [SUM_W-1:0]  sum_acc;
	bit [GRID_W-1:0]        cols_reg;
	bit [GRID_W-1:0]        rows_reg;
	bit [FLOOR_W-1:0]       floor_reg;

	splat_req_t req_q[$];
	grid_resp_t due_resp_q[$];
	splat_req_t cur_req;

	int queued_total = 0;
	int issued = 0;
	int retired = 0;
	int errors = 0;
	int gap_left = 0;
	int burst_left = 0;
	int hold_ticket = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int sink_left = 0;
	sink_mode_t sink_mode = SINK_OPEN;

	int stamp_cnt = 0;
	int query_cnt = 0;
	int oog_cnt = 0;
	int cfg_cnt = 0;
	int sat_hits = 0;
	int clamp_hits = 0;

	logic [COORD_W-1:0] last_cx = '0;
	logic [COORD_W-1:0] last_cy = '0;
	logic [RAD_W-1:0]   last_rad = '0;

	disc_splat_grid_accumulator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.weight     (weight),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_value (cell_value),
		.threat_sum (threat_sum),
		.out_of_grid(out_of_grid),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint grid_cols();
		return (cols_reg > GRID_W'(MAX_WIDTH_DEF)) ? longint'(MAX_WIDTH_DEF) :
			longint'(cols_reg);
	endfunction

	function automatic longint grid_rows();
		return (rows_reg > GRID_W'(MAX_HEIGHT_DEF)) ? longint'(MAX_HEIGHT_DEF) :
			longint'(rows_reg);
	endfunction

	// add wgt to every in-grid cell of the disc, clamp to floor, track the sum
	function automatic void splat_disc(longint cx, longint cy, longint rq, longint wgt);
		longint w, h, x0, y0, x, y, dx, dy, v, acc;
		int unsigned idx;
		w = grid_cols();
		h = grid_rows();
		x0 = (16 * cx >= rq) ? (16 * cx - rq) / 16 : 64'sd0;
		y0 = (16 * cy >= rq) ? (16 * cy - rq) / 16 : 64'sd0;
		for (x = x0; x < w && 16 * x < 16 * cx + rq; x++) begin
			for (y = y0; y < h && 16 * y < 16 * cy + rq; y++) begin
				dx = cx - x;
				dy = cy - y;
				if (256 * (dx * dx + dy * dy) - 128 <= rq * rq) begin
					idx = 32'(y * w + x);
					if (idx < CELLS) begin
						v = longint'(cell_mem[idx]) + wgt;
						if (v > CELL_HI) begin
							v = CELL_HI;
							sat_hits++;
						end
						if (v < CELL_LO)
							v = CELL_LO;
						if (v < longint'(floor_reg)) begin
							v = longint'(floor_reg);
							clamp_hits++;
						end
						cell_mem[idx] = v[CELL_W-1:0];
						acc = longint'(sum_acc) + wgt;
						if (acc > SUM_HI)
							acc = SUM_HI;
						if (acc < SUM_LO)
							acc = SUM_LO;
						sum_acc = acc[SUM_W-1:0];
					end
				end
			end
		end
	endfunction

	function automatic grid_resp_t grid_access(splat_req_t r);
		grid_resp_t res;
		longint w, h, diff;
		int unsigned idx;
		res.cval = '0;
		res.oog = 1'b0;
		if (r.kind == REQ_STAMP) begin
			stamp_cnt++;
			splat_disc(longint'(r.cx), longint'(r.cy), longint'(r.rad), longint'(r.wgt));
		end else begin
			query_cnt++;
			w = grid_cols();
			h = grid_rows();
			if (longint'(r.cx) >= w || longint'(r.cy) >= h) begin
				res.oog = 1'b1;
				oog_cnt++;
			end else begin
				idx = 32'(longint'(r.cy) * w + longint'(r.cx));
				if (idx < CELLS) begin
					diff = longint'(cell_mem[idx]) - longint'(floor_reg);
					res.cval = diff[CELL_W-1:0];
				end
			end
		end
		res.sum = sum_acc;
		return res;
	endfunction

	function automatic void report(string msg);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("%s", msg);
	endfunction

	function automatic splat_req_t mk_req(logic kind, int cx, int cy, int rad, int wgt);
		splat_req_t r;
		r.kind = kind;
		r.cx = COORD_W'(cx);
		r.cy = COORD_W'(cy);
		r.rad = RAD_W'(rad);
		r.wgt = WGT_W'(wgt);
		r.drain = 1'b0;
		return r;
	endfunction

	function automatic int clip_coord(int v);
		return (v < 0) ? 0 : ((v > 255) ? 255 : v);
	endfunction

	// big_pm: per-mille share of stamps with a radius of 16 cells or more
	function automatic splat_req_t rand_request(int big_pm);
		splat_req_t r;
		int span_x, span_y, reach, pick;
		span_x = (grid_cols() < 1) ? 1 : int'(grid_cols());
		span_y = (grid_rows() < 1) ? 1 : int'(grid_rows());
		r.drain = ($urandom_range(0, 99) == 0);
		r.kind = $urandom_range(0, 1) ? REQ_QUERY : REQ_STAMP;
		r.rad = RAD_W'($urandom);
		r.wgt = WGT_W'($urandom);
		if (r.kind == REQ_STAMP) begin
			pick = $urandom_range(0, 999);
			if (pick < big_pm)
				r.rad = RAD_W'($urandom_range(256, 4095));
			else if (pick < 600)
				r.rad = RAD_W'($urandom_range(0, 63));
			else
				r.rad = RAD_W'($urandom_range(64, 200));
			pick = $urandom_range(0, 99);
			if (pick < 40)
				r.wgt = WGT_W'(int'($urandom_range(0, 2000)) - 1000);
			else if (pick < 50)
				r.wgt = WGT_MAX;
			else if (pick < 60)
				r.wgt = WGT_MIN;
			if ($urandom_range(0, 4) != 0) begin
				r.cx = COORD_W'($urandom_range(0, span_x - 1));
				r.cy = COORD_W'($urandom_range(0, span_y - 1));
			end else begin
				r.cx = COORD_W'($urandom);
				r.cy = COORD_W'($urandom);
			end
			last_cx = r.cx;
			last_cy = r.cy;
			last_rad = r.rad;
		end else begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				// probe around the disc stamped last
				reach = int'(last_rad) / 16 + 1;
				r.cx = COORD_W'(clip_coord(int'(last_cx) +
					int'($urandom_range(0, 2 * reach)) - reach));
				r.cy = COORD_W'(clip_coord(int'(last_cy) +
					int'($urandom_range(0, 2 * reach)) - reach));
			end else if (pick < 8) begin
				r.cx = COORD_W'($urandom_range(0, span_x - 1));
				r.cy = COORD_W'($urandom_range(0, span_y - 1));
			end else begin
				r.cx = COORD_W'($urandom);
				r.cy = COORD_W'($urandom);
			end
		end
		return r;
	endfunction

	task automatic post(input splat_req_t r);
		req_q.push_back(r);
		queued_total++;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (queued_total != issued || issued != retired)
			@(posedge clk);
	endtask

	// call at a rising edge; leaves cfg_valid high for the caller to drop
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (idx)
			REG_GRID_WIDTH:  cols_reg = data[GRID_W-1:0];
			REG_GRID_HEIGHT: rows_reg = data[GRID_W-1:0];
			REG_FLOOR_VALUE: floor_reg = data[FLOOR_W-1:0];
			default: ;
		endcase
		cfg_cnt++;
	endtask

	task automatic set_grid(input logic [CFG_DATA_W-1:0] wdata,
			input logic [CFG_DATA_W-1:0] hdata, input logic [CFG_DATA_W-1:0] fdata);
		wait_idle();
		write_reg(REG_GRID_WIDTH, wdata);
		write_reg(REG_GRID_HEIGHT, hdata);
		write_reg(REG_FLOOR_VALUE, fdata);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// request driver: bursts of random length, random gaps in between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_STAMP;
			center_x <= '0;
			center_y <= '0;
			radius <= '0;
			weight <= '0;
			issued <= 0;
		end else begin
			if (in_valid && in_ready) begin
				due_resp_q.push_back(grid_access(cur_req));
				issued <= issued + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (req_q.size() != 0 &&
						(!req_q[0].drain || (!in_valid && issued == retired))) begin
					cur_req = req_q.pop_front();
					req_type <= cur_req.kind;
					center_x <= cur_req.cx;
					center_y <= cur_req.cy;
					radius <= cur_req.rad;
					weight <= cur_req.wgt;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 60);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: stall pattern of its own plus long hold-offs on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (hold_seen != hold_ticket) begin
				hold_seen = hold_ticket;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (sink_left == 0) begin
					sink_mode = sink_mode_t'($urandom_range(0, 3));
					sink_left = $urandom_range(16, 400);
				end else begin
					sink_left--;
				end
				case (sink_mode)
					SINK_OPEN:   out_ready <= 1'b1;
					SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:     out_ready <= ~out_ready;
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (due_resp_q.size() == 0) begin
				report($sformatf("unexpected result: cell %0d sum %0d oog %0b",
					cell_value, threat_sum, out_of_grid));
			end else begin
				if (due_resp_q[0].cval !== cell_value || due_resp_q[0].sum !== threat_sum ||
						due_resp_q[0].oog !== out_of_grid)
					report($sformatf(
						"result %0d mismatch: cell %0d/%0d sum %0d/%0d oog %0b/%0b (exp/act)",
						retired, due_resp_q[0].cval, cell_value, due_resp_q[0].sum,
						threat_sum, due_resp_q[0].oog, out_of_grid));
				void'(due_resp_q.pop_front());
				retired <= retired + 1;
			end
		end
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int cw, ch;
		int big_pm;
		splat_req_t drain_req;
		for (int i = 0; i < CELLS; i++)
			cell_mem[i] = CELL_W'(RESET_FLOOR);
		sum_acc = '0;
		cols_reg = RESET_GRID;
		rows_reg = RESET_GRID;
		floor_reg = RESET_FLOOR;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: fresh cells, field extremes, edges, full grid
		post(mk_req(REQ_QUERY, 0, 0, $urandom, $urandom));
		post(mk_req(REQ_QUERY, 255, 255, $urandom, $urandom));
		post(mk_req(REQ_STAMP, 10, 10, 0, int'(WGT_MAX)));
		post(mk_req(REQ_STAMP, 10, 10, 16, int'(WGT_MAX)));
		post(mk_req(REQ_QUERY, 10, 10, $urandom, $urandom));
		post(mk_req(REQ_QUERY, 11, 10, $urandom, $urandom));
		post(mk_req(REQ_QUERY, 11, 11, $urandom, $urandom));
		post(mk_req(REQ_STAMP, 10, 10, 16, int'(WGT_MIN)));
		post(mk_req(REQ_QUERY, 10, 10, $urandom, $urandom));
		post(mk_req(REQ_STAMP, 0, 0, 40, 1000));
		post(mk_req(REQ_STAMP, 255, 255, 40, -1));
		post(mk_req(REQ_STAMP, 128, 128, int'(RAD_MAX), 3));
		post(mk_req(REQ_QUERY, 0, 255, $urandom, $urandom));

		// raise the floor above the value stored in the probed cell
		set_grid(16'd256, 16'd256, 16'hFFFF);
		post(mk_req(REQ_QUERY, 5, 5, $urandom, $urandom));
		post(mk_req(REQ_STAMP, 5, 5, 8, 1));
		post(mk_req(REQ_QUERY, 5, 5, $urandom, $urandom));

		// empty grid
		set_grid(16'd0, 16'd256, 16'd0);
		post(mk_req(REQ_STAMP, 0, 0, 100, 500));
		post(mk_req(REQ_QUERY, 0, 0, $urandom, $urandom));

		// oversized width and height saturate
		set_grid(16'hFFFF, 16'd300, 16'd256);
		post(mk_req(REQ_QUERY, 255, 255, $urandom, $urandom));
		post(mk_req(REQ_STAMP, 255, 0, 20, -7));

		// single cell grid, shifted cell mapping
		set_grid(16'd1, 16'd1, 16'd0);
		post(mk_req(REQ_QUERY, 0, 0, $urandom, $urandom));
		post(mk_req(REQ_QUERY, 1, 0, $urandom, $urandom));
		post(mk_req(REQ_QUERY, 0, 1, $urandom, $urandom));
		post(mk_req(REQ_STAMP, 0, 0, int'(RAD_MAX), int'(WGT_MAX)));
		post(mk_req(REQ_QUERY, 0, 0, $urandom, $urandom));

		// write to the unused index must change nothing
		wait_idle();
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		@(negedge clk);
		post(mk_req(REQ_QUERY, 0, 0, $urandom, $urandom));

		// pile one cell up with the largest weight
		set_grid(16'd256, 16'd256, 16'd0);
		for (int i = 0; i < SOAK_STAMPS; i++) begin
			post(mk_req(REQ_STAMP, 200, 200, 8, int'(WGT_MAX)));
			if (i % 16 == 15)
				post(mk_req(REQ_QUERY, 200, 200, $urandom, $urandom));
		end
		drain_req = mk_req(REQ_QUERY, 200, 200, $urandom, $urandom);
		drain_req.drain = 1'b1;
		post(drain_req);
		post(mk_req(REQ_QUERY, 201, 200, $urandom, $urandom));
		post(mk_req(REQ_STAMP, 200, 200, 8, int'(WGT_MIN)));
		post(mk_req(REQ_QUERY, 200, 200, $urandom, $urandom));

		// random phases over several grid shapes and floors
		for (int p = 0; p < 4; p++) begin
			big_pm = 4;
			case (p)
				0: set_grid(16'd256, 16'd256, CFG_DATA_W'($urandom_range(0, 1023)));
				1: begin
					cw = $urandom_range(1, 64) | ($urandom & 16'hFE00);
					ch = $urandom_range(1, 256) | ($urandom & 16'hFE00);
					set_grid(CFG_DATA_W'(cw), CFG_DATA_W'(ch), CFG_DATA_W'($urandom));
				end
				2: begin
					big_pm = 100;
					set_grid(CFG_DATA_W'($urandom_range(300, 511)),
						CFG_DATA_W'($urandom_range(1, 16)), 16'd0);
				end
				default: begin
					cw = $urandom_range(1, 256) | ($urandom & 16'hFE00);
					ch = $urandom_range(1, 256) | ($urandom & 16'hFE00);
					set_grid(CFG_DATA_W'(cw), CFG_DATA_W'(ch), CFG_DATA_W'($urandom));
				end
			endcase
			// hold the receiver off while the queue keeps offering requests
			if (p == 1 || p == 3)
				hold_ticket++;
			for (int i = 0; i < PHASE_ITEMS; i++)
				post(rand_request(big_pm));
		end

		wait_idle();
		repeat (300) @(posedge clk);
		if (due_resp_q.size() != 0)
			report($sformatf("%0d results never arrived", due_resp_q.size()));
		$display("covered %0d stamps and %0d queries (%0d off the grid), %0d register writes",
			stamp_cnt, query_cnt, oog_cnt, cfg_cnt);
		$display("cell updates saturated at the ceiling %0d times, lifted to the floor %0d times",
			sat_hits, clamp_hits);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
src/dsga_pkg.sv
src/dsga_scan.sv
src/disc_splat_grid_accumulator.sv
verif/tb_disc_splat_grid_accumulator.sv
